// File: rtl/salc_pkg.sv
package salc_pkg;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int SETB_W     = 3;
  localparam int BLKB_W     = 6;
  localparam int WAYS_CFG_W = 4;
  // ways count compare width, holds up to 16 ways
  localparam int WCNT_W     = 5;
  // set index before wrap: at most seven set bits
  localparam int IDX_W      = 7;
  localparam int TOT_W      = 7;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [1:0] {
    ACT_FETCH  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_t;

  localparam logic [REG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS       = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
    logic last;
  } salc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } salc_sts_t;

  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: rtl/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [salc_pkg::idx_w(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [salc_pkg::idx_w(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/salc_ctrl.sv
module salc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_action,
  output logic                  in_stall,
  input  salc_pkg::salc_sts_t   sts,
  output salc_pkg::salc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CMP   = 4'b0100,
    S_RD    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   twice_r, twice_nxt;

  always_comb begin
    state_nxt = state_r;
    twice_nxt = twice_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          // instruction fetch is taken and dropped
          if (in_action != salc_pkg::ACT_FETCH) begin
            state_nxt = S_CMP;
            twice_nxt = (in_action == salc_pkg::ACT_MODIFY);
          end
        end
      end
      S_CMP: begin
        // hold the set lookup until the output register can take the result
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          cmd.last   = !twice_r;
          twice_nxt  = 1'b0;
          state_nxt  = twice_r ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      twice_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      twice_r <= twice_nxt;
    end
  end

endmodule

// File: rtl/salc_dp.sv
module salc_dp #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  salc_pkg::salc_cmd_t                          cmd,
  output salc_pkg::salc_sts_t                          sts,
  input  logic [salc_pkg::SETB_W-1:0]                  cfg_set_bits,
  input  logic [salc_pkg::BLKB_W-1:0]                  cfg_block_bits,
  input  logic [salc_pkg::WAYS_CFG_W-1:0]              cfg_ways,
  input  logic [salc_pkg::ADDR_W-1:0]                  in_address,
  output logic                                         ram_we,
  output logic [salc_pkg::idx_w(NUM_SETS)-1:0]         ram_waddr,
  output logic [NUM_WAYS*(1+salc_pkg::idx_w(NUM_WAYS)+salc_pkg::TAG_W)-1:0] ram_wdata,
  output logic [salc_pkg::idx_w(NUM_SETS)-1:0]         ram_raddr,
  input  logic [NUM_WAYS*(1+salc_pkg::idx_w(NUM_WAYS)+salc_pkg::TAG_W)-1:0] ram_rdata,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [1:0]                                   out_outcome,
  output logic                                         out_last,
  output logic [salc_pkg::OUT_CNT_W-1:0]               out_hit_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]               out_miss_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]               out_eviction_total
);

  localparam int SET_W   = salc_pkg::idx_w(NUM_SETS);
  localparam int RANK_W  = salc_pkg::idx_w(NUM_WAYS);
  localparam int WAY_W   = salc_pkg::idx_w(NUM_WAYS);
  localparam int TAG_W   = salc_pkg::TAG_W;
  localparam int ADDR_W  = salc_pkg::ADDR_W;
  localparam int IDX_W   = salc_pkg::IDX_W;
  localparam int IDX_N   = 1 << IDX_W;
  localparam int TOT_W   = salc_pkg::TOT_W;
  localparam int WCNT_W  = salc_pkg::WCNT_W;
  localparam int OW      = salc_pkg::OUT_CNT_W;
  localparam int ENTRY_W = 1 + RANK_W + TAG_W;
  localparam int ROW_W   = NUM_WAYS * ENTRY_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);

  // address split
  logic [ADDR_W-1:0] blk_shift;
  logic [IDX_W-1:0]  idx_mask;
  logic [IDX_W-1:0]  idx_raw;
  logic [TOT_W-1:0]  tot;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [SET_W-1:0]  set_lut [IDX_N];

  for (genvar g = 0; g < IDX_N; g++) begin : g_lut
    assign set_lut[g] = SET_W'(g % NUM_SETS);
  end

  assign blk_shift = in_address >> cfg_block_bits;
  assign idx_mask  = ~({IDX_W{1'b1}} << cfg_set_bits);
  assign idx_raw   = blk_shift[IDX_W-1:0] & idx_mask;
  assign in_set    = set_lut[idx_raw];
  assign tot       = TOT_W'(cfg_set_bits) + TOT_W'(cfg_block_bits);
  assign in_tag    = (tot >= TOT_W'(ADDR_W)) ? '0 : (in_address >> tot);

  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [SET_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign sts.clear_done = (clr_cnt_r == SET_W'(NUM_SETS - 1));

  // row unpack: tag low, then rank, then valid
  logic [NUM_WAYS-1:0] way_valid;
  logic [RANK_W-1:0]   way_rank [NUM_WAYS];
  logic [TAG_W-1:0]    way_tag  [NUM_WAYS];
  logic [NUM_WAYS-1:0] in_use;
  logic [WCNT_W-1:0]   ways_eff;

  for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
    assign way_tag[w]   = ram_rdata[w*ENTRY_W +: TAG_W];
    assign way_rank[w]  = ram_rdata[w*ENTRY_W + TAG_W +: RANK_W];
    assign way_valid[w] = ram_rdata[w*ENTRY_W + TAG_W + RANK_W];
    assign in_use[w]    = (WCNT_W'(w) < ways_eff);
  end

  always_comb begin
    if (cfg_ways == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (WCNT_W'(cfg_ways) > WCNT_W'(NUM_WAYS)) begin
      ways_eff = WCNT_W'(NUM_WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg_ways);
    end
  end

  // lookup: first hit, first empty way, oldest way (lowest index on ties)
  logic               hit_any, empty_any;
  logic [WAY_W-1:0]   hit_way, empty_way, victim, tgt;
  logic [RANK_W-1:0]  best, tgt_rank;
  salc_pkg::outcome_t oc;

  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    best      = '0;
    victim    = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (in_use[w] && way_valid[w] && (way_tag[w] == tag_r) && !hit_any) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !way_valid[w] && !empty_any) begin
        empty_any = 1'b1;
        empty_way = WAY_W'(w);
      end
      if (in_use[w] && (way_rank[w] > best)) begin
        best   = way_rank[w];
        victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    priority if (hit_any) begin
      oc  = salc_pkg::OC_HIT;
      tgt = hit_way;
    end else if (empty_any) begin
      oc  = salc_pkg::OC_FILL;
      tgt = empty_way;
    end else begin
      oc  = salc_pkg::OC_EVICT;
      tgt = victim;
    end
  end

  assign tgt_rank = way_rank[tgt];

  logic [ROW_W-1:0] row_new;

  always_comb begin
    row_new = ram_rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == tgt) begin
        row_new[w*ENTRY_W + TAG_W + RANK_W] = 1'b1;
        row_new[w*ENTRY_W + TAG_W +: RANK_W] = '0;
        if (oc != salc_pkg::OC_HIT) begin
          row_new[w*ENTRY_W +: TAG_W] = tag_r;
        end
      end else if (in_use[w] && way_valid[w] && (way_rank[w] < RANK_MAX) &&
                   ((oc != salc_pkg::OC_HIT) || (way_rank[w] < tgt_rank))) begin
        // on a hit only ways newer than the hit way grow older
        row_new[w*ENTRY_W + TAG_W +: RANK_W] = way_rank[w] + RANK_W'(1);
      end
    end
  end

  assign ram_raddr = cmd.load ? in_set : set_r;
  assign ram_we    = cmd.clear | cmd.commit;
  assign ram_waddr = cmd.clear ? clr_cnt_r : set_r;
  assign ram_wdata = cmd.clear ? '0 : row_new;

  // running counters and output register
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;
  logic [COUNT_WIDTH-1:0] misses_r, misses_nxt;
  logic [COUNT_WIDTH-1:0] evicts_r, evicts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_outcome_r;
  logic                   out_last_r;
  logic [OW-1:0]          out_hit_r, out_miss_r, out_evict_r;

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (cmd.commit) begin
      unique case (oc)
        salc_pkg::OC_HIT: begin
          hits_nxt = hits_r + COUNT_WIDTH'(1);
        end
        salc_pkg::OC_FILL: begin
          misses_nxt = misses_r + COUNT_WIDTH'(1);
        end
        default: begin
          misses_nxt = misses_r + COUNT_WIDTH'(1);
          evicts_nxt = evicts_r + COUNT_WIDTH'(1);
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= oc;
      out_last_r    <= cmd.last;
      out_hit_r     <= OW'(hits_nxt);
      out_miss_r    <= OW'(misses_nxt);
      out_evict_r   <= OW'(evicts_nxt);
    end
  end

  assign sts.out_busy      = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_last           = out_last_r;
  assign out_hit_total      = out_hit_r;
  assign out_miss_total     = out_miss_r;
  assign out_eviction_total = out_evict_r;

endmodule

// File: rtl/set_assoc_lru_cache_sim.sv
// Set-associative cache simulator with exact LRU ranks, fed by a trace.
// Input channel (in_valid / in_stall): one request is an action and a
// 64-bit byte address. A load or store yields one result, a modify two
// (the second with out_last set), an instruction fetch none.
// Output channel (out_valid / out_stall): outcome (hit, fill, eviction)
// plus the running hit, miss and eviction totals after that access.
// Timing: each access first reads the set's row from the line RAM, then
// compares and writes back the row, and its result is registered in the
// output register. A modify reads the row again before its second access;
// a fetch is taken with no access. A new request waits for the last commit.
// A request is taken while a finished result still sits in the output
// register; if the receiver stalls, the next access waits in its compare
// step until that register frees up.
// Reset: configuration goes to set_bits 0, block_bits 0, ways_in_use 1,
// counters clear, then the line RAM is swept one set per cycle, every set
// once, with in_stall high. The APB port is served throughout.
module set_assoc_lru_cache_sim #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [salc_pkg::ADDR_W-1:0]         in_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_outcome,
  output logic                                out_last,
  output logic [salc_pkg::OUT_CNT_W-1:0]      out_hit_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]      out_miss_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]      out_eviction_total,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SET_W  = salc_pkg::idx_w(NUM_SETS);
  localparam int ROW_W  = NUM_WAYS * (1 + salc_pkg::idx_w(NUM_WAYS) + salc_pkg::TAG_W);
  localparam int SETB_W = salc_pkg::SETB_W;
  localparam int BLKB_W = salc_pkg::BLKB_W;
  localparam int WAYS_W = salc_pkg::WAYS_CFG_W;
  localparam int DATA_W = salc_pkg::CFG_DATA_W;
  localparam int RIDX_W = salc_pkg::REG_IDX_W;

  // configuration registers
  logic                 cfg_wr;
  logic [RIDX_W-1:0]    cfg_idx;
  logic [SETB_W-1:0]    set_bits_r, set_bits_nxt;
  logic [BLKB_W-1:0]    block_bits_r, block_bits_nxt;
  logic [WAYS_W-1:0]    ways_r, ways_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[RIDX_W+1:2];

  always_comb begin
    set_bits_nxt   = set_bits_r;
    block_bits_nxt = block_bits_r;
    ways_nxt       = ways_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        salc_pkg::REG_SET_BITS:   set_bits_nxt   = cfg_pwdata[SETB_W-1:0];
        salc_pkg::REG_BLOCK_BITS: block_bits_nxt = cfg_pwdata[BLKB_W-1:0];
        salc_pkg::REG_WAYS:       ways_nxt       = cfg_pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      salc_pkg::REG_SET_BITS:   cfg_prdata = DATA_W'(set_bits_r);
      salc_pkg::REG_BLOCK_BITS: cfg_prdata = DATA_W'(block_bits_r);
      salc_pkg::REG_WAYS:       cfg_prdata = DATA_W'(ways_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= WAYS_W'(1);
    end else begin
      set_bits_r   <= set_bits_nxt;
      block_bits_r <= block_bits_nxt;
      ways_r       <= ways_nxt;
    end
  end

  salc_pkg::salc_cmd_t cmd;
  salc_pkg::salc_sts_t sts;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  salc_dp #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_set_bits       (set_bits_r),
    .cfg_block_bits     (block_bits_r),
    .cfg_ways           (ways_r),
    .in_address         (in_address),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_last           (out_last),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

  // one row per set holds every way's tag, rank and valid bit
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/salc_chk.sv
module salc_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_outcome,
  input logic                                out_last,
  input logic [salc_pkg::OUT_CNT_W-1:0]      out_hit_total,
  input logic [salc_pkg::OUT_CNT_W-1:0]      out_miss_total,
  input logic [salc_pkg::OUT_CNT_W-1:0]      out_eviction_total
);

  // totals are compared in their low 16 bits so any counter width of at least 16 works
  localparam int CW = 16;

  logic          out_acc;
  logic [CW-1:0] sum_now, sum_prev_r;
  logic [CW-1:0] evict_now, evict_prev_r;
  logic          is_evict;

  assign out_acc   = out_valid && !out_stall;
  assign sum_now   = CW'(out_hit_total) + CW'(out_miss_total);
  assign evict_now = CW'(out_eviction_total);
  assign is_evict  = (out_outcome == salc_pkg::OC_EVICT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_prev_r   <= '0;
      evict_prev_r <= '0;
    end else if (out_acc) begin
      sum_prev_r   <= sum_now;
      evict_prev_r <= evict_now;
    end
  end

  // every delivered result is exactly one more access
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (sum_now == sum_prev_r + CW'(1)))
    else $error("hit plus miss total did not advance by one");

  a_evict_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (evict_now == evict_prev_r + CW'(is_evict)))
    else $error("eviction total disagrees with outcome");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == salc_pkg::OC_HIT || out_outcome == salc_pkg::OC_FILL ||
                   out_outcome == salc_pkg::OC_EVICT))
    else $error("undefined outcome code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_outcome) && $stable(out_last) &&
                                  $stable(out_hit_total) && $stable(out_miss_total) &&
                                  $stable(out_eviction_total)))
    else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_sim salc_chk u_chk (.*);

// File: sim/tb_set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;

  localparam int SETS = 64;
  localparam int WAYS = 8;
  localparam int PLAN_ROWS = 33;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_REQUESTS = 75;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;
  localparam logic [salc_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         code;    // action or register index
    logic [63:0]        value;
    logic               typed;
    salc_pkg::outcome_t first;
    salc_pkg::outcome_t second;
  } plan_row_t;

  typedef struct packed {
    salc_pkg::outcome_t outcome;
    logic               last;
    logic [31:0]        hits;
    logic [31:0]        misses;
    logic [31:0]        evicts;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = salc_pkg::ACT_FETCH;
  logic [63:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_outcome;
  logic        out_last;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;
  logic [31:0] out_eviction_total;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [salc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  set_assoc_lru_cache_sim u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_last           (out_last),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache model state
  logic [2:0]  cur_set_bits = '0;
  logic [5:0]  cur_block_bits = '0;
  logic [3:0]  cur_ways = 4'd1;
  bit          line_live [SETS][WAYS];
  logic [63:0] line_tags [SETS][WAYS];
  bit [2:0]    line_age [SETS][WAYS];
  logic [31:0] model_hits = '0;
  logic [31:0] model_misses = '0;
  logic [31:0] evict_count = '0;

  access_result_t expected_results [$];
  access_result_t want;
  plan_row_t      plan [PLAN_ROWS];
  int             mismatches = 0;
  int             idle_cycles = 0;
  bit             no_gaps = 1'b0;
  int unsigned    rx_draw;
  int unsigned    rx_wait = 0;

  function automatic void promote_way(int unsigned set_no, int unsigned way,
                                      int unsigned limit, int unsigned ways);
    for (int unsigned i = 0; i < ways; i++) begin
      if (i != way && line_live[set_no][i] && line_age[set_no][i] < limit &&
          line_age[set_no][i] < WAYS - 1)
        line_age[set_no][i] = 3'(line_age[set_no][i] + 1);
    end
    line_age[set_no][way] = 0;
  endfunction

  function automatic salc_pkg::outcome_t lru_access(logic [63:0] addr);
    int unsigned ways, set_no, total, victim, best, found;
    logic [63:0] tag;
    ways = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : 32'(cur_ways));
    set_no = 32'(((addr >> cur_block_bits) & ((64'd1 << cur_set_bits) - 64'd1)) % SETS);
    total = 32'(cur_set_bits) + 32'(cur_block_bits);
    tag = (total >= 64) ? 64'd0 : (addr >> total);
    found = ways;
    for (int unsigned i = 0; i < ways; i++) begin
      if (found == ways && line_live[set_no][i] && line_tags[set_no][i] == tag)
        found = i;
    end
    if (found < ways) begin
      promote_way(set_no, found, line_age[set_no][found], ways);
      model_hits = model_hits + 32'd1;
      return salc_pkg::OC_HIT;
    end
    for (int unsigned i = 0; i < ways; i++) begin
      if (found == ways && !line_live[set_no][i])
        found = i;
    end
    if (found < ways) begin
      promote_way(set_no, found, WAYS, ways);
      line_live[set_no][found] = 1'b1;
      line_tags[set_no][found] = tag;
      model_misses = model_misses + 32'd1;
      return salc_pkg::OC_FILL;
    end
    // oldest way loses, lowest index among equal ranks
    victim = 0;
    best = 0;
    for (int unsigned i = 0; i < ways; i++) begin
      if (line_age[set_no][i] > best) begin
        best = line_age[set_no][i];
        victim = i;
      end
    end
    promote_way(set_no, victim, WAYS, ways);
    line_tags[set_no][victim] = tag;
    model_misses = model_misses + 32'd1;
    evict_count = evict_count + 32'd1;
    return salc_pkg::OC_EVICT;
  endfunction

  function automatic void predict_request(logic [1:0] action, logic [63:0] addr, logic typed,
                                          salc_pkg::outcome_t first,
                                          salc_pkg::outcome_t second);
    salc_pkg::outcome_t got;
    access_result_t r;
    int unsigned n;
    if (action == salc_pkg::ACT_FETCH)
      return;
    n = (action == salc_pkg::ACT_MODIFY) ? 2 : 1;
    for (int unsigned k = 0; k < n; k++) begin
      got = lru_access(addr);
      if (typed)
        got = (k == 0) ? first : second;
      r.outcome = got;
      r.last = (k == n - 1);
      r.hits = model_hits;
      r.misses = model_misses;
      r.evicts = evict_count;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic send_request(logic [1:0] action, logic [63:0] addr);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_address <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic issue(logic [1:0] action, logic [63:0] addr, logic typed,
                       salc_pkg::outcome_t first, salc_pkg::outcome_t second);
    predict_request(action, addr, typed, first, second);
    send_request(action, addr);
  endtask

  // hold off new requests until every result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    logic [31:0] keep;
    case (idx)
      salc_pkg::REG_SET_BITS:   keep = data & 32'h7;
      salc_pkg::REG_BLOCK_BITS: keep = data & 32'h3f;
      salc_pkg::REG_WAYS:       keep = data & 32'hf;
      default:                  keep = '0;
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      salc_pkg::REG_SET_BITS:   cur_set_bits = keep[2:0];
      salc_pkg::REG_BLOCK_BITS: cur_block_bits = keep[5:0];
      salc_pkg::REG_WAYS:       cur_ways = keep[3:0];
      default:                  ;
    endcase
    if (idx != REG_SPARE) begin
      cfg_pwrite <= 1'b0;
      cfg_penable <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (cfg_pready !== 1'b1);
      check_field("register readback", keep, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // receiver: fresh stall draw after every accepted result
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) begin
      rx_draw = no_gaps ? 0 : $urandom_range(0, 8);
      rx_wait <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual outcome %0d", $time, out_outcome);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("outcome", want.outcome, out_outcome);
        check_field("last", want.last, out_last);
        check_field("hit_total", want.hits, out_hit_total);
        check_field("miss_total", want.misses, out_miss_total);
        check_field("eviction_total", want.evicts, out_eviction_total);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0]  sb;
    logic [5:0]  bb;
    logic [3:0]  wv;
    logic [63:0] tag_pool [12];
    logic [63:0] set_pool [4];
    logic [63:0] addr;
    logic [1:0]  act;
    int unsigned pool_n, set_n, ways_eff, total, pick;

    plan = '{
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h0, 1'b1, salc_pkg::OC_FILL, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h0, 1'b1, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, {64{1'b1}}, 1'b1, salc_pkg::OC_EVICT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_MODIFY, {64{1'b1}}, 1'b1, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_FETCH, 64'h1234, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_MODIFY, 64'h0, 1'b1, salc_pkg::OC_EVICT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_WAYS, 64'd0, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h0, 1'b1, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, REG_SPARE, 64'd5, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h0, 1'b1, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_WAYS, 64'd15, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_SET_BITS, 64'd7, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_BLOCK_BITS, 64'd63, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, {1'b1, 63'd0}, 1'b1, salc_pkg::OC_FILL, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h0, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, {64{1'b1}}, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_SET_BITS, 64'd6, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_BLOCK_BITS, 64'd58, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_MODIFY, {64{1'b1}}, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_BLOCK_BITS, 64'd0, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_SET_BITS, 64'd7, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h40, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h7f, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_CFG, salc_pkg::REG_SET_BITS, 64'd0, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h1, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h2, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h3, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h4, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h5, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h6, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h7, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_STORE, 64'h8, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT},
      '{ROW_REQ, salc_pkg::ACT_LOAD, 64'h0, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        settle();
        write_register(plan[r].code, plan[r].value[31:0]);
      end else begin
        issue(plan[r].code, plan[r].value, plan[r].typed, plan[r].first, plan[r].second);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin sb = 3'd7; bb = 6'd63; wv = 4'd15; end
        1: begin sb = 3'd0; bb = 6'd0;  wv = 4'd0;  end
        2: begin sb = 3'd6; bb = 6'd58; wv = 4'd8;  end
        default: begin
          sb = 3'($urandom_range(0, 7));
          bb = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                             6'($urandom_range(0, 8));
          wv = 4'($urandom_range(0, 15));
        end
      endcase
      // unused upper data bits carry noise
      write_register(salc_pkg::REG_SET_BITS, ($urandom & ~32'h7) | 32'(sb));
      write_register(salc_pkg::REG_BLOCK_BITS, ($urandom & ~32'h3f) | 32'(bb));
      write_register(salc_pkg::REG_WAYS, ($urandom & ~32'hf) | 32'(wv));

      ways_eff = (wv == 0) ? 1 : ((wv > WAYS) ? WAYS : 32'(wv));
      pool_n = ways_eff + $urandom_range(1, 3);
      for (int i = 0; i < 12; i++) tag_pool[i] = {$urandom, $urandom};
      set_n = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) set_pool[i] = 64'($urandom_range(0, 127));
      no_gaps = ($urandom_range(0, 3) == 0);
      total = 32'(cur_set_bits) + 32'(cur_block_bits);

      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        pick = $urandom_range(0, 9);
        act = (pick == 0) ? salc_pkg::ACT_FETCH : (pick <= 3) ? salc_pkg::ACT_LOAD :
              (pick <= 6) ? salc_pkg::ACT_STORE : salc_pkg::ACT_MODIFY;
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          // contended set and tag pools so hits and evictions stay frequent
          addr = ({$urandom, $urandom} & ((64'd1 << cur_block_bits) - 64'd1)) |
                 ((set_pool[$urandom_range(0, set_n - 1)] &
                   ((64'd1 << cur_set_bits) - 64'd1)) << cur_block_bits);
          if (total < 64)
            addr = addr | (tag_pool[$urandom_range(0, pool_n - 1)] << total);
        end
        issue(act, addr, 1'b0, salc_pkg::OC_HIT, salc_pkg::OC_HIT);
      end
    end

    settle();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
